@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file tgs_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TGS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TGS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/tgs_pkg.sv @@
// ---------------------------------------------------------------------------
// tgs_pkg
// Types, widths and helpers of the tile grid shift scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package tgs_pkg;

  localparam int GRID_DIM = 3;                     // 2 .. 4
  localparam int NSLOTS   = GRID_DIM * GRID_DIM;
  localparam int CW       = (GRID_DIM > 2) ? $clog2(GRID_DIM) : 1;
  localparam int IW       = $clog2(NSLOTS);
  localparam int DW       = $clog2(GRID_DIM + 1) + 1;  // clamped shift, signed
  localparam int SW       = DW + 1;                    // source coordinate, signed
  localparam int TW       = 21;                        // tile coordinate
  localparam int FW       = 2;                         // slot index field
  localparam int DXW      = TW + 1;                    // full-precision difference
  localparam int QDEPTH   = 2;                         // power of two
  localparam int QAW      = $clog2(QDEPTH);
  localparam int IN_DW    = 48;
  localparam int OUT_DW   = 56;

  localparam logic [TW-1:0] TAG_NONE = '1;

  typedef enum logic {
    MODE_CENTER = 1'b0,
    MODE_FILL   = 1'b1
  } mode_t;

  typedef enum logic {
    JOB_MOVE  = 1'b0,
    JOB_FETCH = 1'b1
  } job_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SHIFT,
    B_CHECK,
    B_FLUSH
  } back_state_t;

  typedef struct packed {
    mode_t                 mode;
    logic [TW-1:0]         tx;
    logic [TW-1:0]         ty;
    logic [IW-1:0]         idx;
    logic                  do_shift;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
  } cmd_t;

  typedef struct packed {
    job_kind_t     kind;
    logic [TW-1:0] fx;
    logic [TW-1:0] fy;
    logic [FW-1:0] dc;
    logic [FW-1:0] dr;
    logic [FW-1:0] sc;
    logic [FW-1:0] sr;
  } job_t;

  function automatic logic [IW-1:0] slot_idx(input logic [CW-1:0] col,
                                             input logic [CW-1:0] row);
    return IW'(int'(row) * GRID_DIM + int'(col));
  endfunction

endpackage

`default_nettype wire

@@ hdl/tgs_front.sv @@
// ---------------------------------------------------------------------------
// tgs_front
// Takes input beats, tracks the last center and turns each in-range beat into a
// command for the back end: a tag write or a center job with clamped shift.
// ---------------------------------------------------------------------------
`default_nettype none

module tgs_front
  import tgs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_DW-1:0] in_tdata,
  input  wire logic             in_tuser,
  output logic                  q_push,
  input  wire logic             q_full,
  output cmd_t                  q_cmd
);

  logic [TW-1:0]          prev_x_r, prev_y_r, prev_x_nxt, prev_y_nxt;
  logic                   seen_r, seen_nxt;
  logic [TW-1:0]          cx, cy;
  logic [FW-1:0]          slot_col, slot_row;
  logic signed [DXW-1:0]  dx_full, dy_full;
  logic                   fill_ok;
  logic                   accept;
  mode_t                  mode;

  // shifts of a grid width or more all behave the same
  function automatic logic signed [DW-1:0] clamp_d(input logic signed [DXW-1:0] d);
    logic signed [DXW-1:0] gp;
    logic signed [DXW-1:0] gn;
    logic signed [DW-1:0]  r;
    gp = DXW'(GRID_DIM);
    gn = -gp;
    priority if (d >= gp) r = gp[DW-1:0];
    else if (d <= gn)     r = gn[DW-1:0];
    else                  r = d[DW-1:0];
    return r;
  endfunction

  assign mode     = mode_t'(in_tuser);
  assign cx       = in_tdata[TW-1:0];
  assign cy       = in_tdata[2*TW-1:TW];
  assign slot_col = in_tdata[2*TW+FW-1:2*TW];
  assign slot_row = in_tdata[2*TW+2*FW-1:2*TW+FW];

  assign dx_full = $signed({cx[TW-1], cx}) - $signed({prev_x_r[TW-1], prev_x_r});
  assign dy_full = $signed({cy[TW-1], cy}) - $signed({prev_y_r[TW-1], prev_y_r});

  assign fill_ok   = (int'(slot_col) < GRID_DIM) && (int'(slot_row) < GRID_DIM);
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  // out-of-range fills are taken and dropped
  assign q_push    = accept && ((mode == MODE_CENTER) || fill_ok);

  always_comb begin
    q_cmd.mode     = mode;
    q_cmd.tx       = cx;
    q_cmd.ty       = cy;
    q_cmd.idx      = IW'(int'(slot_row) * GRID_DIM + int'(slot_col));
    q_cmd.do_shift = seen_r && ((dx_full != '0) || (dy_full != '0));
    q_cmd.dx       = clamp_d(dx_full);
    q_cmd.dy       = clamp_d(dy_full);
  end

  always_comb begin
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    seen_nxt   = seen_r;
    if (accept && (mode == MODE_CENTER)) begin
      prev_x_nxt = cx;
      prev_y_nxt = cy;
      seen_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      seen_r   <= 1'b0;
    end else begin
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tgs_fifo.sv @@
// ---------------------------------------------------------------------------
// tgs_fifo
// Short command queue between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tgs_fifo
  import tgs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tgs_back.sv @@
// ---------------------------------------------------------------------------
// tgs_back
// Holds the slot tags; walks the grid one slot a cycle unless stalled: a shift
// pass moves tags in place if the center moved, then a check pass issues fetches.
// ---------------------------------------------------------------------------
`default_nettype none

module tgs_back
  import tgs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire cmd_t              q_head,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,   // fetch_tile_x, fetch_tile_y, dest_col,
                                               // dest_row, src_col, src_row, zero pad
  output logic                   out_tuser,   // job_kind
  output logic                   out_tlast    // last_job
);

  localparam logic signed [SW-1:0] GS = SW'(GRID_DIM);

  back_state_t     state_r, state_nxt;
  cmd_t            cur_r;
  logic [CW-1:0]   ix_r, iy_r;
  logic [TW-1:0]   tag_x_r [NSLOTS];
  logic [TW-1:0]   tag_y_r [NSLOTS];
  logic [NSLOTS-1:0] valid_r;
  logic            pend_v_r;
  job_t            pend_r;
  logic            ov_r;
  job_t            oj_r;
  logic            olast_r;

  logic [CW-1:0]        gx, gy;
  logic signed [SW-1:0] sx, sy;
  logic                 src_in;
  logic [IW-1:0]        d_idx, s_idx, rd_idx;
  logic [TW-1:0]        rd_x, rd_y;
  logic [TW-1:0]        ftx, fty;
  logic                 hit;
  logic                 last_slot;
  logic                 walking;
  job_t                 job;
  logic                 job_v;
  logic                 out_free;
  logic                 adv;

  logic                 wr_en, wr_valid;
  logic [IW-1:0]        wr_idx;
  logic [TW-1:0]        wr_x, wr_y;
  logic                 o_load, o_last;
  job_t                 o_job;
  logic                 pend_load, pend_clr;

  // walk datapath
  always_comb begin
    gx = ix_r;
    gy = iy_r;
    // walk against the shift so each source is read before it is overwritten
    if ((state_r == B_SHIFT) && cur_r.dx[DW-1]) gx = CW'(GRID_DIM - 1) - ix_r;
    if ((state_r == B_SHIFT) && cur_r.dy[DW-1]) gy = CW'(GRID_DIM - 1) - iy_r;
    sx     = $signed({{(SW-CW){1'b0}}, gx}) + $signed({cur_r.dx[DW-1], cur_r.dx});
    sy     = $signed({{(SW-CW){1'b0}}, gy}) + $signed({cur_r.dy[DW-1], cur_r.dy});
    src_in = !sx[SW-1] && (sx < GS) && !sy[SW-1] && (sy < GS);
    d_idx  = slot_idx(gx, gy);
    s_idx  = slot_idx(sx[CW-1:0], sy[CW-1:0]);
    rd_idx = (state_r == B_SHIFT) ? s_idx : d_idx;
    rd_x   = tag_x_r[rd_idx];
    rd_y   = tag_y_r[rd_idx];
    ftx    = cur_r.tx + TW'(ix_r) - TW'(GRID_DIM / 2);
    fty    = cur_r.ty + TW'(iy_r) - TW'(GRID_DIM / 2);
    hit    = valid_r[d_idx] && (rd_x == ftx) && (rd_y == fty);
    last_slot = (ix_r == CW'(GRID_DIM - 1)) && (iy_r == CW'(GRID_DIM - 1));
    walking   = (state_r == B_SHIFT) || (state_r == B_CHECK);

    job_v = 1'b0;
    job   = '0;
    if (state_r == B_SHIFT) begin
      job_v   = src_in;
      job.kind = JOB_MOVE;
      job.dc  = FW'(gx);
      job.dr  = FW'(gy);
      job.sc  = FW'(sx[CW-1:0]);
      job.sr  = FW'(sy[CW-1:0]);
    end else if (state_r == B_CHECK) begin
      job_v   = !hit;
      job.kind = JOB_FETCH;
      job.fx  = ftx;
      job.fy  = fty;
      job.dc  = FW'(gx);
      job.dr  = FW'(gy);
    end

    out_free = !ov_r || out_tready;
    // a new job pushes the held one out; stall if the output is still full
    adv      = !(job_v && pend_v_r && !out_free);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && (q_head.mode == MODE_CENTER)) begin
          state_nxt = q_head.do_shift ? B_SHIFT : B_CHECK;
        end
      end
      B_SHIFT: begin
        if (adv && last_slot) state_nxt = B_CHECK;
      end
      B_CHECK: begin
        if (adv && last_slot) state_nxt = B_FLUSH;
      end
      B_FLUSH: begin
        if (!pend_v_r || out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = d_idx;
    wr_x      = TAG_NONE;
    wr_y      = TAG_NONE;
    wr_valid  = 1'b0;
    o_load    = 1'b0;
    o_last    = 1'b0;
    o_job     = pend_r;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty && (q_head.mode == MODE_FILL)) begin
          wr_en    = 1'b1;
          wr_idx   = q_head.idx;
          wr_x     = q_head.tx;
          wr_y     = q_head.ty;
          wr_valid = 1'b1;
        end
      end
      B_SHIFT, B_CHECK: begin
        if (state_r == B_SHIFT && adv) begin
          wr_en    = 1'b1;
          wr_x     = src_in ? rd_x : TAG_NONE;
          wr_y     = src_in ? rd_y : TAG_NONE;
          wr_valid = src_in && valid_r[s_idx];
        end
        if (job_v && adv) begin
          pend_load = 1'b1;
          o_load    = pend_v_r;
        end
      end
      B_FLUSH: begin
        if (pend_v_r && out_free) begin
          o_load   = 1'b1;
          o_last   = 1'b1;
          pend_clr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ix_r     <= '0;
      iy_r     <= '0;
      valid_r  <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (!walking) begin
        ix_r <= '0;
        iy_r <= '0;
      end else if (adv) begin
        if (ix_r == CW'(GRID_DIM - 1)) begin
          ix_r <= '0;
          iy_r <= last_slot ? '0 : iy_r + 1'b1;
        end else begin
          ix_r <= ix_r + 1'b1;
        end
      end
      if (wr_en) valid_r[wr_idx] <= wr_valid;
      if (pend_load)     pend_v_r <= 1'b1;
      else if (pend_clr) pend_v_r <= 1'b0;
      if (o_load)          ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (wr_en) begin
      tag_x_r[wr_idx] <= wr_x;
      tag_y_r[wr_idx] <= wr_y;
    end
    if (pend_load) pend_r <= job;
    if (o_load) begin
      oj_r    <= o_job;
      olast_r <= o_last;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = oj_r.kind;
  assign out_tlast  = olast_r;
  assign out_tdata  = {{(OUT_DW - 2*TW - 4*FW){1'b0}},
                       oj_r.sr, oj_r.sc, oj_r.dr, oj_r.dc, oj_r.fy, oj_r.fx};

endmodule

`default_nettype wire

@@ hdl/tile_grid_shift_scheduler_unit.sv @@
// ---------------------------------------------------------------------------
// tile_grid_shift_scheduler_unit
// Keeps the slot tags of a square map-tile cache and schedules move and
// fetch jobs when the center tile changes.
// ---------------------------------------------------------------------------
// Input channel (in_*): one beat per event. in_tuser = 0 is a new center tile
//   (in_tdata tile_x/tile_y); in_tuser = 1 reports a tile fetched into slot
//   slot_col/slot_row. A fill beat writes at most one tag and gives no output.
// Output channel (out_*): one beat per job, out_tuser 0 = move, 1 = fetch;
//   out_tlast marks the final job of a center event. A center event that
//   needs no job gives no beat.
// Timing: the back end walks the grid one slot per cycle unless the output
//   stalls, once for the shift (only if the center moved) and once for the
//   tag check. A job goes from the walker into a pending register and then
//   into the output register; each job is held pending until the next one
//   is found or the walk ends, so the last can be marked.
// A two-entry command queue sits between the input and the walker; in_tready
//   drops only while it is full.
// When out_tready is low the walker halts on its next job and the queue fills.
// Reset (rst_n low, synchronous) invalidates every slot and clears the last
//   center; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_grid_shift_scheduler_unit
  import tgs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // tile_x, tile_y, slot_col, slot_row, pad
  input  wire logic              in_tuser,   // mode
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // fetch_tile_x, fetch_tile_y, dest_col,
                                              // dest_row, src_col, src_row, pad
  output logic                   out_tuser,  // job_kind
  output logic                   out_tlast   // last_job
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_cmd, q_head;

  tgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_full    (q_full),
    .q_cmd     (q_cmd)
  );

  tgs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  tgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/tgs_checker.sv @@
// ---------------------------------------------------------------------------
// tgs_checker
// Port-level checks on the job stream of the scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tgs_checker
  import tgs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic              out_tuser
);

  `TGS_ASSERT_RST(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled job dropped")
  `TGS_ASSERT_RST(a_move_no_tile, out_tvalid && !out_tuser |-> out_tdata[2*TW-1:0] == '0, "move job carries tile")
  `TGS_ASSERT_RST(a_fetch_no_src, out_tvalid && out_tuser |-> out_tdata[2*TW+4*FW-1:2*TW+2*FW] == '0, "fetch job carries source")
  `TGS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "job right after reset")

endmodule

bind tile_grid_shift_scheduler_unit tgs_checker u_tgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for tile_grid_shift_scheduler_unit: drives center and
// fill beats with random idling, predicts the move and fetch jobs of every
// center event and compares each output beat field by field.
// ---------------------------------------------------------------------------

module testbench;
  import tgs_pkg::*;

  localparam int ITEM_TARGET  = 460;
  localparam int DRAIN_CYCLES = 2 * NSLOTS + 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam logic [TW-1:0] TILE_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] TILE_MIN = {1'b1, {(TW-1){1'b0}}};

  typedef struct {
    job_kind_t     kind;
    logic [TW-1:0] fx;
    logic [TW-1:0] fy;
    logic [FW-1:0] dc;
    logic [FW-1:0] dr;
    logic [FW-1:0] sc;
    logic [FW-1:0] sr;
    bit            last;
  } grid_job_t;

  // Mirror of the slot tags; turns each accepted event into the jobs it owes.
  class tile_job_scoreboard;
    logic [TW-1:0] tag_x [NSLOTS];
    logic [TW-1:0] tag_y [NSLOTS];
    bit            tag_ok [NSLOTS];
    logic [TW-1:0] center_x, center_y;
    bit            have_center;
    grid_job_t     jobs_due[$];
    int            n_errors;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        tag_x[i]  = TAG_NONE;
        tag_y[i]  = TAG_NONE;
        tag_ok[i] = 1'b0;
      end
      center_x    = '0;
      center_y    = '0;
      have_center = 1'b0;
      n_errors    = 0;
    endfunction

    function void note_event(mode_t mode, logic [TW-1:0] x, logic [TW-1:0] y,
                             logic [FW-1:0] col, logic [FW-1:0] row);
      longint        cx, cy, dx, dy, sx, sy;
      int            gx, gy, d, s, n_before;
      logic [TW-1:0] old_x [NSLOTS];
      logic [TW-1:0] old_y [NSLOTS];
      bit            old_ok [NSLOTS];
      logic [TW-1:0] want_x, want_y;
      grid_job_t     j;

      if (mode == MODE_FILL) begin
        if (col < GRID_DIM && row < GRID_DIM) begin
          d = int'(row) * GRID_DIM + int'(col);
          tag_x[d]  = x;
          tag_y[d]  = y;
          tag_ok[d] = 1'b1;
        end
        return;
      end

      n_before = jobs_due.size();
      cx = longint'($signed(x));
      cy = longint'($signed(y));
      dx = 0;
      dy = 0;
      if (have_center) begin
        dx = cx - longint'($signed(center_x));
        dy = cy - longint'($signed(center_y));
      end

      if (dx != 0 || dy != 0) begin
        old_x  = tag_x;
        old_y  = tag_y;
        old_ok = tag_ok;
        // walk against the shift so no source is overwritten before it is read
        for (int iy = 0; iy < GRID_DIM; iy++) begin
          gy = (dy < 0) ? GRID_DIM - 1 - iy : iy;
          for (int ix = 0; ix < GRID_DIM; ix++) begin
            gx = (dx < 0) ? GRID_DIM - 1 - ix : ix;
            sx = gx + dx;
            sy = gy + dy;
            d  = gy * GRID_DIM + gx;
            if (sx >= 0 && sx < GRID_DIM && sy >= 0 && sy < GRID_DIM) begin
              s = int'(sy) * GRID_DIM + int'(sx);
              tag_x[d]  = old_x[s];
              tag_y[d]  = old_y[s];
              tag_ok[d] = old_ok[s];
              j = '{JOB_MOVE, '0, '0, FW'(gx), FW'(gy), FW'(sx), FW'(sy), 1'b0};
              jobs_due.push_back(j);
            end else begin
              tag_x[d]  = TAG_NONE;
              tag_y[d]  = TAG_NONE;
              tag_ok[d] = 1'b0;
            end
          end
        end
      end

      center_x    = x;
      center_y    = y;
      have_center = 1'b1;

      for (gy = 0; gy < GRID_DIM; gy++) begin
        for (gx = 0; gx < GRID_DIM; gx++) begin
          d      = gy * GRID_DIM + gx;
          want_x = TW'(cx + gx - GRID_DIM / 2);
          want_y = TW'(cy + gy - GRID_DIM / 2);
          if (!(tag_ok[d] && tag_x[d] == want_x && tag_y[d] == want_y)) begin
            j = '{JOB_FETCH, want_x, want_y, FW'(gx), FW'(gy), '0, '0, 1'b0};
            jobs_due.push_back(j);
          end
        end
      end

      if (jobs_due.size() > n_before) jobs_due[jobs_due.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_job(logic kind, logic [OUT_DW-1:0] data, logic last);
      grid_job_t j;
      if (jobs_due.size() == 0) begin
        $error("job beat with nothing outstanding: kind %0h data %0h", kind, data);
        n_errors++;
        return;
      end
      j = jobs_due.pop_front();
      compare_field("job_kind", j.kind, kind);
      compare_field("fetch_tile_x", j.fx, data[0 +: TW]);
      compare_field("fetch_tile_y", j.fy, data[TW +: TW]);
      compare_field("dest_col", j.dc, data[2*TW +: FW]);
      compare_field("dest_row", j.dr, data[2*TW+FW +: FW]);
      compare_field("src_col", j.sc, data[2*TW+2*FW +: FW]);
      compare_field("src_row", j.sr, data[2*TW+3*FW +: FW]);
      compare_field("last_job", j.last, last);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;
  logic              out_tlast;

  tile_job_scoreboard sb;
  int n_items       = 0;
  int burst_left    = 0;
  int cycle_count   = 0;
  bit hold_request  = 1'b0;
  logic [TW-1:0] cur_cx, cur_cy;

  tile_grid_shift_scheduler_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send(input mode_t mode, input logic [TW-1:0] x, input logic [TW-1:0] y,
                      input logic [FW-1:0] col, input logic [FW-1:0] row);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ((n_items / 60) % 4 == 2) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {{(IN_DW-2*TW-2*FW){1'b0}}, row, col, y, x};
    do @(posedge clk); while (!in_tready);
    sb.note_event(mode, x, y, col, row);
    if (mode == MODE_CENTER) begin
      cur_cx = x;
      cur_cy = y;
    end
    if (!(mode == MODE_FILL && (col >= GRID_DIM || row >= GRID_DIM))) n_items++;
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (sb.jobs_due.size() != 0) @(posedge clk);
    // a center event may still be walking the grid with no job to show for it
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [TW-1:0] next_coord(input logic [TW-1:0] cur, input int pick);
    if (pick < 10) return cur;
    if (pick < 80) return cur + TW'(int'($urandom_range(0, 4)) - 2);
    if (pick < 90) return cur + TW'(int'($urandom_range(0, 2*GRID_DIM + 4)) - GRID_DIM - 2);
    if (pick < 95) return TW'($urandom);
    return $urandom_range(0, 1) ? TILE_MAX - TW'($urandom_range(0, 3))
                                : TILE_MIN + TW'($urandom_range(0, 3));
  endfunction

  // Fill every slot with the tile it should hold around the current center.
  task automatic fill_all();
    for (int gy = 0; gy < GRID_DIM; gy++)
      for (int gx = 0; gx < GRID_DIM; gx++)
        send(MODE_FILL, cur_cx + TW'(gx - GRID_DIM/2), cur_cy + TW'(gy - GRID_DIM/2),
             FW'(gx), FW'(gy));
  endtask

  // receiver: per-beat random stall, calm stretches, one long hold-off
  initial begin
    int stall;
    int hold;
    int beats;
    stall = 0;
    hold  = 0;
    beats = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_job(out_tuser, out_tdata, out_tlast);
        beats++;
        stall = ((beats / 50) % 3 == 1) ? 0 : $urandom_range(0, 16);
      end
      if (hold_request) begin
        hold = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int pick, k, gx, gy;
    bit held, drained;
    logic [TW-1:0] nx, ny;

    sb = new();
    held    = 1'b0;
    drained = 1'b0;
    cur_cx  = '0;
    cur_cy  = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_CENTER;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first center, fills incl. a real (-1,-1) tile and bad slots,
    // repeated center, small and oversized shifts, coordinate wrap at the
    // extremes, and a center that needs no job at all
    send(MODE_CENTER, '0, '0, '0, '0);
    send(MODE_FILL, TW'(-1), TW'(-1), 2'd0, 2'd0);
    send(MODE_FILL, '0, '0, 2'd1, 2'd1);
    send(MODE_FILL, TW'(1), TW'(1), 2'd2, 2'd2);
    send(MODE_FILL, TW'(5), TW'(5), 2'd3, 2'd1);
    send(MODE_FILL, TW'(5), TW'(5), 2'd1, 2'd3);
    send(MODE_CENTER, '0, '0, '0, '0);
    send(MODE_CENTER, TW'(1), '0, '0, '0);
    send(MODE_CENTER, '0, TW'(-1), '0, '0);
    send(MODE_CENTER, TW'(GRID_DIM), TW'(-1), 2'd3, 2'd3);
    send(MODE_CENTER, TILE_MAX, TILE_MAX, '0, '0);
    send(MODE_FILL, TILE_MIN, TILE_MIN, 2'd2, 2'd2);
    send(MODE_FILL, TILE_MAX, TILE_MAX, 2'd1, 2'd1);
    send(MODE_CENTER, TILE_MAX, TILE_MAX, '0, '0);
    send(MODE_CENTER, TILE_MAX - TW'(1), TILE_MAX - TW'(1), '0, '0);
    send(MODE_CENTER, TILE_MIN, TILE_MIN, '0, '0);
    fill_all();
    send(MODE_CENTER, TILE_MIN, TILE_MIN, '0, '0);

    while (n_items < ITEM_TARGET) begin
      if (!held && n_items >= 150) begin
        hold_request = 1'b1;
        burst_left   = 40;
        held         = 1'b1;
      end
      if (!drained && n_items >= 320) begin
        wait_drain();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send(mode_t'($urandom_range(0, 1)), TW'($urandom), TW'($urandom),
             FW'($urandom), FW'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        nx = next_coord(cur_cx, pick);
        ny = next_coord(cur_cy, pick < 10 ? pick : $urandom_range(10, 99));
        send(MODE_CENTER, nx, ny, FW'($urandom), FW'($urandom));
        if ($urandom_range(0, 9) == 0) begin
          fill_all();
        end else begin
          k = $urandom_range(0, NSLOTS);
          repeat (k) begin
            gx   = $urandom_range(0, GRID_DIM - 1);
            gy   = $urandom_range(0, GRID_DIM - 1);
            pick = $urandom_range(0, 99);
            if (pick < 85)
              send(MODE_FILL, cur_cx + TW'(gx - GRID_DIM/2), cur_cy + TW'(gy - GRID_DIM/2),
                   FW'(gx), FW'(gy));
            else if (pick < 93)
              send(MODE_FILL, TW'($urandom), TW'($urandom), FW'(gx), FW'(gy));
            else if (pick < 97)
              send(MODE_FILL, TW'($urandom), TW'($urandom), 2'd3, FW'(gy));
            else
              send(MODE_FILL, TW'($urandom), TW'($urandom), FW'(gx), 2'd3);
          end
        end
      end
    end

    wait_drain();
    if (sb.n_errors == 0 && sb.jobs_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
